// ===== hdl/striped_64bit_stream_hash_macros.svh =====
// ----------------------------------------------------------------------------
// striped_64bit_stream_hash assertion macros
// Shared concurrent assertion forms for the stream hash checker.
// ----------------------------------------------------------------------------
`ifndef STRIPED_64BIT_STREAM_HASH_MACROS_SVH
`define STRIPED_64BIT_STREAM_HASH_MACROS_SVH

// same-cycle implication, off while in reset
`define SH64_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define SH64_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// condition that must hold in the cycle after reset is seen
`define SH64_ASSERT_RST(lbl, clk, rst_n, cons, msg) \
    lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) else $error(msg);

`endif

// ===== hdl/sh64_pkg.sv =====
// ----------------------------------------------------------------------------
// sh64_pkg
// Constants, lane tables, command and status types of the stream hash.
// ----------------------------------------------------------------------------
`default_nettype none

package sh64_pkg;

    localparam logic [63:0] P1 = 64'd11400714785074694791;
    localparam logic [63:0] P2 = 64'd14029467366897019727;
    localparam logic [63:0] P3 = 64'd1609587929392839161;
    localparam logic [63:0] P4 = 64'd9650029242287828579;
    localparam logic [63:0] P5 = 64'd2870177450012600261;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_MUL_IN,
        ST_WAIT_IN,
        ST_MUL_OUT,
        ST_WAIT_OUT,
        ST_MIX_A,
        ST_WAIT_A,
        ST_MIX_B,
        ST_WAIT_B,
        ST_FOLD,
        ST_XOR4,
        ST_WSUM,
        ST_COMBINE,
        ST_EMIT
    } t_state;

    // operand pair for the shared 64-bit multiplier
    typedef enum logic [1:0] {
        MUL_WORD_IN,
        MUL_LANE_OUT,
        MUL_MIX2,
        MUL_MIX3
    } t_mul_sel;

    // update of the work register
    typedef enum logic [2:0] {
        V_HOLD,
        V_TAIL,
        V_ZERO,
        V_ROT,
        V_POST29,
        V_POST32,
        V_XOR4,
        V_XSUM
    } t_v_op;

    typedef struct packed {
        logic     latch;
        logic     store;
        logic     k_clr;
        logic     k_inc;
        logic     mul_start;
        t_mul_sel mul_sel;
        t_v_op    v_op;
        logic     lane_wr;
        logic     lane0_xor;
        logic     pcnt_clr;
        logic     wsum_clr;
        logic     wsum_add;
        logic     emit;
        logic     lanes_init;
    } t_cmd;

    typedef struct packed {
        logic pcnt3;
        logic last;
        logic full;
        logic mul_done;
        logic k_last;
        logic out_busy;
    } t_status;

    function automatic logic [63:0] lane_reset(input logic [1:0] k);
        logic [63:0] r;
        case (k)
            2'd0:    r = P1;
            2'd1:    r = P2;
            2'd2:    r = P3;
            default: r = P4;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] lane_mul_in(input logic [1:0] k);
        return lane_reset(k);
    endfunction

    function automatic logic [63:0] lane_mul_out(input logic [1:0] k);
        logic [63:0] r;
        case (k)
            2'd0:    r = P2;
            2'd1:    r = P3;
            2'd2:    r = P4;
            default: r = P5;
        endcase
        return r;
    endfunction

    // fixed per-lane left rotation
    function automatic logic [63:0] lane_rotl(input logic [63:0] x, input logic [1:0] k);
        logic [63:0] r;
        case (k)
            2'd0:    r = {x[32:0], x[63:33]};
            2'd1:    r = {x[34:0], x[63:35]};
            2'd2:    r = {x[36:0], x[63:37]};
            default: r = {x[40:0], x[63:41]};
        endcase
        return r;
    endfunction

    // weights of the final lane sum
    function automatic logic [3:0] lane_weight(input logic [1:0] k);
        logic [3:0] r;
        case (k)
            2'd0:    r = 4'd3;
            2'd1:    r = 4'd5;
            2'd2:    r = 4'd7;
            default: r = 4'd11;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/striped_64bit_stream_hash.sv =====
// ----------------------------------------------------------------------------
// striped_64bit_stream_hash
// Usage:
//   Slave stream s_* takes one 64-bit message word per item, with its valid
//   byte count in tdata and tlast on the final word of a message. Master
//   stream m_* gives one 64-bit hash item per message, after its last word.
//   Multiplier: the lane and mixer products run on one shared multiplier
//   (issue, three 32 x 32 partial products, a final add and the done
//   cycle). A word that is only stored is kept as a pending word. A word
//   that completes a 32-byte stripe takes eight products. A last word
//   also passes through the mixer and lane fold before its hash is emitted.
//   The hash sits in an output register: the next message word is taken
//   while it waits; only the next hash hand-off waits for the receiver.
//   Reset (synchronous, active low) returns the lanes to their start values,
//   drops any partial stripe and clears the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module striped_64bit_stream_hash (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [71:0] i_s_tdata,   // data_word[63:0], byte_count[67:64], zero[71:68]
    input  wire logic        i_s_tlast,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [63:0]      o_m_tdata    // hash_value[63:0]
);

    sh64_pkg::t_cmd    w_cmd;
    sh64_pkg::t_status w_status;

    // sequencer
    sh64_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_status   (w_status),
        .o_in_ready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    // lanes and arithmetic
    sh64_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_data_word  (i_s_tdata[63:0]),
        .i_byte_count (i_s_tdata[67:64]),
        .i_last       (i_s_tlast),
        .i_out_ready  (i_m_tready),
        .o_status     (w_status),
        .o_out_valid  (o_m_tvalid),
        .o_hash_value (o_m_tdata)
    );

endmodule

`default_nettype wire

// ===== hdl/sh64_mul.sv =====
// ----------------------------------------------------------------------------
// sh64_mul
// Low 64 bits of a 64 x 64 product from three 32 x 32 partial products,
// one per cycle, result valid with a one-cycle done pulse.
// ----------------------------------------------------------------------------
`default_nettype none

module sh64_mul (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    output logic             o_done,
    output logic [63:0]      o_prod
);

    logic        r_busy;
    logic        r_done;
    logic [1:0]  r_step;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_p;
    logic [63:0] r_acc;
    logic [31:0] w_x;
    logic [31:0] w_y;
    logic [63:0] w_prod;

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_done <= r_busy && (r_step == 2'd3);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // partial product operand select
    always_comb begin
        case (r_step)
            2'd0: begin
                w_x = r_a[31:0];
                w_y = r_b[31:0];
            end
            2'd1: begin
                w_x = r_a[31:0];
                w_y = r_b[63:32];
            end
            default: begin
                w_x = r_a[63:32];
                w_y = r_b[31:0];
            end
        endcase
    end

    assign w_prod = w_x * w_y;

    // product register and accumulator
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end else if (r_busy) begin
            case (r_step)
                2'd0: begin
                    r_p <= w_prod;
                end
                2'd1: begin
                    r_acc <= r_p;
                    r_p   <= w_prod;
                end
                2'd2: begin
                    r_acc <= r_acc + {r_p[31:0], 32'd0};
                    r_p   <= w_prod;
                end
                default: begin
                    r_acc <= r_acc + {r_p[31:0], 32'd0};
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

// ===== hdl/sh64_datapath.sv =====
// ----------------------------------------------------------------------------
// sh64_datapath
// Lane registers, pending words, tail fold, work register, output register
// and the shared multiplier, driven by controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

module sh64_datapath (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire sh64_pkg::t_cmd   i_cmd,
    input  wire logic [63:0]      i_data_word,
    input  wire logic [3:0]       i_byte_count,
    input  wire logic             i_last,
    input  wire logic             i_out_ready,
    output sh64_pkg::t_status     o_status,
    output logic                  o_out_valid,
    output logic [63:0]           o_hash_value
);

    logic [63:0] r_lanes [4];
    logic [63:0] r_pend  [3];
    logic [1:0]  r_pcnt;
    logic [1:0]  r_k;
    logic        r_out_valid;
    logic [63:0] r_out;
    logic [63:0] r_word;
    logic [3:0]  r_cnt;
    logic        r_last;
    logic [63:0] r_v;
    logic [63:0] r_wsum;

    logic [63:0] w_mul_a;
    logic [63:0] w_mul_b;
    logic        w_mul_done;
    logic [63:0] w_prod;
    logic [63:0] w_word_k;
    logic [63:0] w_tail;
    logic [63:0] w_mask;

    // word feeding lane k
    always_comb begin
        case (r_k)
            2'd0:    w_word_k = r_pend[0];
            2'd1:    w_word_k = r_pend[1];
            2'd2:    w_word_k = r_pend[2];
            default: w_word_k = r_word;
        endcase
    end

    // multiplier operands
    always_comb begin
        case (i_cmd.mul_sel)
            sh64_pkg::MUL_WORD_IN: begin
                w_mul_a = w_word_k;
                w_mul_b = sh64_pkg::lane_mul_in(r_k);
            end
            sh64_pkg::MUL_LANE_OUT: begin
                w_mul_a = r_v;
                w_mul_b = sh64_pkg::lane_mul_out(r_k);
            end
            sh64_pkg::MUL_MIX2: begin
                w_mul_a = r_v ^ (r_v >> 33);
                w_mul_b = sh64_pkg::P2;
            end
            default: begin
                w_mul_a = r_v;
                w_mul_b = sh64_pkg::P3;
            end
        endcase
    end

    sh64_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    // tail fold: pending words ORed with the valid bytes of the last word
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            w_mask[8*b +: 8] = (r_cnt[3] || (r_cnt[2:0] > 3'(b))) ? 8'hff : 8'h00;
        end
        w_tail = r_word & w_mask;
        if (r_pcnt != 2'd0) begin
            w_tail = w_tail | r_pend[0];
        end
        if (r_pcnt[1]) begin
            w_tail = w_tail | r_pend[1];
        end
        if (r_pcnt == 2'd3) begin
            w_tail = w_tail | r_pend[2];
        end
    end

    // lanes, counters and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 4; j++) begin
                r_lanes[j] <= sh64_pkg::lane_reset(2'(j));
            end
            r_pcnt      <= 2'd0;
            r_k         <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.k_clr) begin
                r_k <= 2'd0;
            end else if (i_cmd.k_inc) begin
                r_k <= r_k + 2'd1;
            end
            if (i_cmd.lanes_init || i_cmd.pcnt_clr) begin
                r_pcnt <= 2'd0;
            end else if (i_cmd.store) begin
                r_pcnt <= r_pcnt + 2'd1;
            end
            if (i_cmd.lanes_init) begin
                for (int j = 0; j < 4; j++) begin
                    r_lanes[j] <= sh64_pkg::lane_reset(2'(j));
                end
            end else if (i_cmd.lane_wr) begin
                r_lanes[r_k] <= w_prod;
            end else if (i_cmd.lane0_xor) begin
                r_lanes[0] <= r_lanes[0] ^ r_v;
            end
        end
    end

    // input capture, pending store, work register, weighted sum, output data
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_word <= i_data_word;
            r_cnt  <= i_byte_count;
            r_last <= i_last;
        end
        if (i_cmd.store) begin
            r_pend[r_pcnt] <= r_word;
        end
        case (i_cmd.v_op)
            sh64_pkg::V_TAIL:   r_v <= w_tail;
            sh64_pkg::V_ZERO:   r_v <= 64'd0;
            sh64_pkg::V_ROT:    r_v <= sh64_pkg::lane_rotl(r_lanes[r_k] + w_prod, r_k);
            sh64_pkg::V_POST29: r_v <= w_prod ^ (w_prod >> 29);
            sh64_pkg::V_POST32: r_v <= w_prod ^ (w_prod >> 32);
            sh64_pkg::V_XOR4:   r_v <= r_lanes[0] ^ r_lanes[1] ^ r_lanes[2] ^ r_lanes[3];
            sh64_pkg::V_XSUM:   r_v <= r_v ^ r_wsum;
            default:            r_v <= r_v;
        endcase
        if (i_cmd.wsum_clr) begin
            r_wsum <= 64'd0;
        end else if (i_cmd.wsum_add) begin
            r_wsum <= r_wsum + r_lanes[r_k] * {60'd0, sh64_pkg::lane_weight(r_k)};
        end
        if (i_cmd.emit) begin
            r_out <= r_v;
        end
    end

    // status toward the controller
    always_comb begin
        o_status.pcnt3    = (r_pcnt == 2'd3);
        o_status.last     = r_last;
        o_status.full     = r_cnt[3];
        o_status.mul_done = w_mul_done;
        o_status.k_last   = (r_k == 2'd3);
        o_status.out_busy = r_out_valid && !i_out_ready;
    end

    assign o_out_valid  = r_out_valid;
    assign o_hash_value = r_out;

endmodule

`default_nettype wire

// ===== hdl/sh64_ctrl.sv =====
// ----------------------------------------------------------------------------
// sh64_ctrl
// Sequencer of the stream hash: item intake, stripe absorb per lane,
// tail and final mixer passes, lane fold and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module sh64_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire sh64_pkg::t_status i_status,
    output logic                   o_in_ready,
    output sh64_pkg::t_cmd         o_cmd
);

    sh64_pkg::t_state r_state;
    sh64_pkg::t_state n_state;
    logic             r_final;
    logic             n_final;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sh64_pkg::ST_IDLE;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_final <= n_final;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_final = r_final;
        case (r_state)
            sh64_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = sh64_pkg::ST_DISPATCH;
                end
            end
            sh64_pkg::ST_DISPATCH: begin
                n_final = 1'b0;
                if (!i_status.last && !i_status.pcnt3) begin
                    n_state = sh64_pkg::ST_IDLE;
                end else if (i_status.pcnt3 && (!i_status.last || i_status.full)) begin
                    n_state = sh64_pkg::ST_MUL_IN;
                end else begin
                    n_state = sh64_pkg::ST_MIX_A;
                end
            end
            sh64_pkg::ST_MUL_IN:  n_state = sh64_pkg::ST_WAIT_IN;
            sh64_pkg::ST_WAIT_IN: begin
                if (i_status.mul_done) begin
                    n_state = sh64_pkg::ST_MUL_OUT;
                end
            end
            sh64_pkg::ST_MUL_OUT: n_state = sh64_pkg::ST_WAIT_OUT;
            sh64_pkg::ST_WAIT_OUT: begin
                if (i_status.mul_done) begin
                    if (!i_status.k_last) begin
                        n_state = sh64_pkg::ST_MUL_IN;
                    end else if (i_status.last) begin
                        n_state = sh64_pkg::ST_MIX_A;
                    end else begin
                        n_state = sh64_pkg::ST_IDLE;
                    end
                end
            end
            sh64_pkg::ST_MIX_A:  n_state = sh64_pkg::ST_WAIT_A;
            sh64_pkg::ST_WAIT_A: begin
                if (i_status.mul_done) begin
                    n_state = sh64_pkg::ST_MIX_B;
                end
            end
            sh64_pkg::ST_MIX_B:  n_state = sh64_pkg::ST_WAIT_B;
            sh64_pkg::ST_WAIT_B: begin
                if (i_status.mul_done) begin
                    n_state = r_final ? sh64_pkg::ST_EMIT : sh64_pkg::ST_FOLD;
                end
            end
            sh64_pkg::ST_FOLD: n_state = sh64_pkg::ST_XOR4;
            sh64_pkg::ST_XOR4: n_state = sh64_pkg::ST_WSUM;
            sh64_pkg::ST_WSUM: begin
                if (i_status.k_last) begin
                    n_state = sh64_pkg::ST_COMBINE;
                end
            end
            sh64_pkg::ST_COMBINE: begin
                n_final = 1'b1;
                n_state = sh64_pkg::ST_MIX_A;
            end
            sh64_pkg::ST_EMIT: begin
                if (!i_status.out_busy) begin
                    n_final = 1'b0;
                    n_state = sh64_pkg::ST_IDLE;
                end
            end
            default: n_state = sh64_pkg::ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_in_ready       = 1'b0;
        o_cmd.latch      = 1'b0;
        o_cmd.store      = 1'b0;
        o_cmd.k_clr      = 1'b0;
        o_cmd.k_inc      = 1'b0;
        o_cmd.mul_start  = 1'b0;
        o_cmd.mul_sel    = sh64_pkg::MUL_WORD_IN;
        o_cmd.v_op       = sh64_pkg::V_HOLD;
        o_cmd.lane_wr    = 1'b0;
        o_cmd.lane0_xor  = 1'b0;
        o_cmd.pcnt_clr   = 1'b0;
        o_cmd.wsum_clr   = 1'b0;
        o_cmd.wsum_add   = 1'b0;
        o_cmd.emit       = 1'b0;
        o_cmd.lanes_init = 1'b0;
        case (r_state)
            sh64_pkg::ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            sh64_pkg::ST_DISPATCH: begin
                if (!i_status.last && !i_status.pcnt3) begin
                    o_cmd.store = 1'b1;
                end else if (i_status.pcnt3 && (!i_status.last || i_status.full)) begin
                    o_cmd.k_clr = 1'b1;
                end else begin
                    o_cmd.v_op = sh64_pkg::V_TAIL;
                end
            end
            sh64_pkg::ST_MUL_IN: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = sh64_pkg::MUL_WORD_IN;
            end
            sh64_pkg::ST_WAIT_IN: begin
                if (i_status.mul_done) begin
                    o_cmd.v_op = sh64_pkg::V_ROT;
                end
            end
            sh64_pkg::ST_MUL_OUT: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = sh64_pkg::MUL_LANE_OUT;
            end
            sh64_pkg::ST_WAIT_OUT: begin
                if (i_status.mul_done) begin
                    o_cmd.lane_wr = 1'b1;
                    if (i_status.k_last) begin
                        o_cmd.pcnt_clr = 1'b1;
                        if (i_status.last) begin
                            o_cmd.v_op = sh64_pkg::V_ZERO;
                        end
                    end else begin
                        o_cmd.k_inc = 1'b1;
                    end
                end
            end
            sh64_pkg::ST_MIX_A: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = sh64_pkg::MUL_MIX2;
            end
            sh64_pkg::ST_WAIT_A: begin
                if (i_status.mul_done) begin
                    o_cmd.v_op = sh64_pkg::V_POST29;
                end
            end
            sh64_pkg::ST_MIX_B: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = sh64_pkg::MUL_MIX3;
            end
            sh64_pkg::ST_WAIT_B: begin
                if (i_status.mul_done) begin
                    o_cmd.v_op = sh64_pkg::V_POST32;
                end
            end
            sh64_pkg::ST_FOLD: begin
                o_cmd.lane0_xor = 1'b1;
            end
            sh64_pkg::ST_XOR4: begin
                o_cmd.v_op     = sh64_pkg::V_XOR4;
                o_cmd.wsum_clr = 1'b1;
                o_cmd.k_clr    = 1'b1;
            end
            sh64_pkg::ST_WSUM: begin
                o_cmd.wsum_add = 1'b1;
                o_cmd.k_inc    = 1'b1;
            end
            sh64_pkg::ST_COMBINE: begin
                o_cmd.v_op = sh64_pkg::V_XSUM;
            end
            sh64_pkg::ST_EMIT: begin
                if (!i_status.out_busy) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.lanes_init = 1'b1;
                end
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/sh64_checker.sv =====
// ----------------------------------------------------------------------------
// sh64_checker
// Port-level checks of the stream hash, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "striped_64bit_stream_hash_macros.svh"

module sh64_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        i_s_tready,
    input wire logic        i_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [63:0] i_m_tdata
);

    // a stalled hash stays offered
    `SH64_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid, "hash dropped while stalled")

    // a stalled hash keeps its value
    `SH64_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, $stable(i_m_tdata), "hash changed while stalled")

    // every item is decoded before the next one is taken
    `SH64_ASSERT_NXT(a_in_gap, i_clk, i_rst_n, i_s_tvalid && i_s_tready, !i_s_tready, "item taken during decode")

    // a new hash never appears right after an item was taken
    `SH64_ASSERT_IMP(a_emit_gap, i_clk, i_rst_n, $rose(i_m_tvalid), !$past(i_s_tvalid && i_s_tready), "hash emitted too early")

    // reset empties the output register
    `SH64_ASSERT_RST(a_rst_out, i_clk, i_rst_n, !i_m_tvalid, "hash valid after reset")

endmodule

bind striped_64bit_stream_hash sh64_checker u_sh64_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);

`default_nettype wire
